FILE: rtl/roiefp_pkg.sv
// Shared types and constants of the ROI event frame parser.
package roiefp_pkg;

  localparam logic [15:0] SYNC_WORD     = 16'hFFFF;
  localparam logic [15:0] ROLL_HIGH_MIN = 16'd65513;
  localparam logic [15:0] ROLL_LOW_MAX  = 16'd20;
  localparam logic [16:0] OVER_SAT      = 17'h1FFFF;

  localparam logic [1:0] KIND_PIXEL   = 2'd0;
  localparam logic [1:0] KIND_SUMMARY = 2'd1;
  localparam logic [1:0] KIND_BOUNDS  = 2'd2;
  localparam logic [1:0] KIND_EMPTY   = 2'd3;

  typedef enum logic [10:0] {
    PH_HUNT   = 11'b000_0000_0001,
    PH_COLMIN = 11'b000_0000_0010,
    PH_COLMAX = 11'b000_0000_0100,
    PH_ROWMIN = 11'b000_0000_1000,
    PH_ROWMAX = 11'b000_0001_0000,
    PH_BUFID  = 11'b000_0010_0000,
    PH_TLOW   = 11'b000_0100_0000,
    PH_THIGH  = 11'b000_1000_0000,
    PH_RUN1   = 11'b001_0000_0000,
    PH_RUN2   = 11'b010_0000_0000,
    PH_PIX    = 11'b100_0000_0000
  } phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [8:0]  row;
    logic [8:0]  col;
    logic [16:0] index;
    logic [15:0] value;
    logic        over;
    logic [15:0] buffer_id;
    logic [47:0] tick;
    logic [31:0] run_seconds;
    logic [16:0] over_count;
    logic        last;
  } result_t;

endpackage

FILE: rtl/roi_event_frame_parser_unit.sv
// ROI event frame parser: sync hunt, header decode, pixel sweep and result queue.

// Takes one 16-bit stream word per cycle. Each accepted word is decoded in the
// cycle it arrives and its results (none, one, or two on the last pixel of an
// in-bounds region: the pixel and the event summary) go into a four-entry
// result queue that feeds the output port, one request per cycle. in_ready is
// low while the queue holds three or more results, so the input sustains one
// word per cycle as long as the output is taken at that rate; only the last
// pixel's pixel-plus-summary pair puts two results in the queue. Region index
// and time tick are built from adders and shifts; no multiplier sits in any path.
module roi_event_frame_parser_unit #(
  parameter int COLS = 300,
  parameter int ROWS = 352
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] stream_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  result_kind,
  output logic [8:0]  pixel_row,
  output logic [8:0]  pixel_col,
  output logic [16:0] region_index,
  output logic [15:0] pixel_value,
  output logic        over_threshold,
  output logic [15:0] buffer_id,
  output logic [47:0] time_tick,
  output logic [31:0] run_seconds,
  output logic [16:0] over_count,
  output logic        last_of_event
);

  localparam logic [15:0] COL_LAST = 16'(COLS - 1);
  localparam logic [15:0] ROW_LAST = 16'(ROWS - 1);

  logic [15:0] pixel_threshold;

  roiefp_pkg::phase_t phase, phase_next;
  logic [15:0] col_min, col_max, row_min, row_max;
  logic [15:0] col_min_next, col_max_next, row_min_next, row_max_next;
  logic [15:0] cur_row, cur_col, cur_row_next, cur_col_next;
  logic [16:0] row_off, row_off_next;
  logic [16:0] col_term, col_term_next;
  logic [16:0] width, width_next;
  logic        bad_region, bad_region_next;
  logic [15:0] event_buffer_id, event_buffer_id_next;
  logic [15:0] time_low_word, time_low_word_next;
  logic [15:0] prev_time_high, prev_time_high_next;
  logic        have_prev_time, have_prev_time_next;
  logic [15:0] rollover_count, rollover_count_next;
  logic [47:0] tick, tick_next;
  logic [31:0] run_words, run_words_next;
  logic [16:0] over_counter, over_counter_next;

  roiefp_pkg::result_t res0, res1;
  logic [1:0] push_count;

  roiefp_pkg::result_t queue [4];
  logic [1:0] head, tail;
  logic [2:0] count;
  logic       accept, pop;

  assign accept = in_valid && in_ready;
  assign pop    = out_valid && out_ready;

  always_comb begin
    logic [31:0] high_scaled;
    logic        over;
    logic        last;
    phase_next           = phase;
    col_min_next         = col_min;
    col_max_next         = col_max;
    row_min_next         = row_min;
    row_max_next         = row_max;
    cur_row_next         = cur_row;
    cur_col_next         = cur_col;
    row_off_next         = row_off;
    col_term_next        = col_term;
    width_next           = width;
    bad_region_next      = bad_region;
    event_buffer_id_next = event_buffer_id;
    time_low_word_next   = time_low_word;
    prev_time_high_next  = prev_time_high;
    have_prev_time_next  = have_prev_time;
    rollover_count_next  = rollover_count;
    tick_next            = tick;
    run_words_next       = run_words;
    over_counter_next    = over_counter;
    res0                 = '0;
    res1                 = '0;
    push_count           = 2'd0;
    // h * 65534 = h * 65536 - h * 2
    high_scaled = {stream_word, 16'd0} - {15'd0, stream_word, 1'b0};
    over = stream_word > pixel_threshold;
    last = 1'b0;

    case (phase)
      roiefp_pkg::PH_COLMIN: begin
        col_min_next = stream_word;
        phase_next   = roiefp_pkg::PH_COLMAX;
      end
      roiefp_pkg::PH_COLMAX: begin
        col_max_next = stream_word;
        phase_next   = roiefp_pkg::PH_ROWMIN;
      end
      roiefp_pkg::PH_ROWMIN: begin
        row_min_next = stream_word;
        phase_next   = roiefp_pkg::PH_ROWMAX;
      end
      roiefp_pkg::PH_ROWMAX: begin
        row_max_next = stream_word;
        width_next   = 17'(col_max - col_min) + 17'd1;
        if (col_min > col_max || row_min > stream_word) begin
          res0.kind  = roiefp_pkg::KIND_EMPTY;
          res0.last  = 1'b1;
          push_count = 2'd1;
          phase_next = roiefp_pkg::PH_HUNT;
        end else begin
          bad_region_next = (col_max > COL_LAST) || (stream_word > ROW_LAST);
          phase_next      = roiefp_pkg::PH_BUFID;
        end
      end
      roiefp_pkg::PH_BUFID: begin
        event_buffer_id_next = stream_word;
        phase_next           = roiefp_pkg::PH_TLOW;
      end
      roiefp_pkg::PH_TLOW: begin
        time_low_word_next = stream_word;
        phase_next         = roiefp_pkg::PH_THIGH;
      end
      roiefp_pkg::PH_THIGH: begin
        if (have_prev_time && prev_time_high > roiefp_pkg::ROLL_HIGH_MIN &&
            stream_word < roiefp_pkg::ROLL_LOW_MAX) begin
          rollover_count_next = rollover_count + 16'd1;
        end
        // low + high * 65534 always fits in 32 bits
        tick_next           = {rollover_count_next,
                               high_scaled + {16'd0, time_low_word}};
        prev_time_high_next = stream_word;
        have_prev_time_next = 1'b1;
        phase_next          = roiefp_pkg::PH_RUN1;
      end
      roiefp_pkg::PH_RUN1: begin
        run_words_next = {stream_word, 16'd0};
        phase_next     = roiefp_pkg::PH_RUN2;
      end
      roiefp_pkg::PH_RUN2: begin
        run_words_next    = {run_words[31:16], stream_word};
        cur_row_next      = row_min;
        cur_col_next      = col_min;
        row_off_next      = '0;
        col_term_next     = '0;
        over_counter_next = '0;
        phase_next        = roiefp_pkg::PH_PIX;
      end
      roiefp_pkg::PH_PIX: begin
        if (!bad_region) begin
          res0.kind      = roiefp_pkg::KIND_PIXEL;
          res0.row       = cur_row[8:0];
          res0.col       = cur_col[8:0];
          res0.index     = row_off + col_term;
          res0.value     = stream_word;
          res0.over      = over;
          res0.buffer_id = event_buffer_id;
          push_count     = 2'd1;
          if (over && over_counter != roiefp_pkg::OVER_SAT) begin
            over_counter_next = over_counter + 17'd1;
          end
        end
        // advance the sweep: column inner, row outer
        if (cur_col == col_max) begin
          cur_col_next  = col_min;
          col_term_next = '0;
          if (cur_row == row_max) begin
            last = 1'b1;
          end else begin
            cur_row_next = cur_row + 16'd1;
            row_off_next = row_off + 17'd1;
          end
        end else begin
          cur_col_next  = cur_col + 16'd1;
          col_term_next = col_term + width;
        end
        if (last) begin
          roiefp_pkg::result_t trailer;
          trailer             = '0;
          trailer.kind        = bad_region ? roiefp_pkg::KIND_BOUNDS
                                           : roiefp_pkg::KIND_SUMMARY;
          trailer.buffer_id   = event_buffer_id;
          trailer.tick        = tick;
          trailer.run_seconds = run_words;
          trailer.over_count  = bad_region ? 17'd0 : over_counter_next;
          trailer.last        = 1'b1;
          if (bad_region) begin
            res0       = trailer;
            push_count = 2'd1;
          end else begin
            res1       = trailer;
            push_count = 2'd2;
          end
          phase_next = roiefp_pkg::PH_HUNT;
        end
      end
      default: begin
        phase_next = (stream_word == roiefp_pkg::SYNC_WORD) ? roiefp_pkg::PH_COLMIN
                                                            : roiefp_pkg::PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_threshold <= '0;
    end else if (cfg_write) begin
      pixel_threshold <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= roiefp_pkg::PH_HUNT;
      col_min         <= '0;
      col_max         <= '0;
      row_min         <= '0;
      row_max         <= '0;
      cur_row         <= '0;
      cur_col         <= '0;
      row_off         <= '0;
      col_term        <= '0;
      width           <= '0;
      bad_region      <= 1'b0;
      event_buffer_id <= '0;
      time_low_word   <= '0;
      prev_time_high  <= '0;
      have_prev_time  <= 1'b0;
      rollover_count  <= '0;
      tick            <= '0;
      run_words       <= '0;
      over_counter    <= '0;
    end else if (accept) begin
      phase           <= phase_next;
      col_min         <= col_min_next;
      col_max         <= col_max_next;
      row_min         <= row_min_next;
      row_max         <= row_max_next;
      cur_row         <= cur_row_next;
      cur_col         <= cur_col_next;
      row_off         <= row_off_next;
      col_term        <= col_term_next;
      width           <= width_next;
      bad_region      <= bad_region_next;
      event_buffer_id <= event_buffer_id_next;
      time_low_word   <= time_low_word_next;
      prev_time_high  <= prev_time_high_next;
      have_prev_time  <= have_prev_time_next;
      rollover_count  <= rollover_count_next;
      tick            <= tick_next;
      run_words       <= run_words_next;
      over_counter    <= over_counter_next;
    end
  end

  // result queue: up to two writes and one read per cycle
  always_ff @(posedge clk) begin
    if (accept && push_count != 2'd0) begin
      queue[tail] <= res0;
    end
    if (accept && push_count == 2'd2) begin
      queue[tail + 2'd1] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (accept) begin
        tail <= tail + push_count;
      end
      if (pop) begin
        head <= head + 2'd1;
      end
      count <= count + (accept ? {1'b0, push_count} : 3'd0) - {2'd0, pop};
    end
  end

  // hold input while fewer than two queue slots are free
  assign in_ready  = count < 3'd3;
  assign out_valid = count != 3'd0;

  assign result_kind    = queue[head].kind;
  assign pixel_row      = queue[head].row;
  assign pixel_col      = queue[head].col;
  assign region_index   = queue[head].index;
  assign pixel_value    = queue[head].value;
  assign over_threshold = queue[head].over;
  assign buffer_id      = queue[head].buffer_id;
  assign time_tick      = queue[head].tick;
  assign run_seconds    = queue[head].run_seconds;
  assign over_count     = queue[head].over_count;
  assign last_of_event  = queue[head].last;

endmodule

FILE: verif/roi_event_frame_parser_unit_tb.sv
// Self-checking testbench of the ROI event frame parser: framing, pixel sweep and event trailers.
module roi_event_frame_parser_unit_tb;

  localparam int COLS = 300;
  localparam int ROWS = 352;
  localparam logic [63:0] TICK_HIGH_SCALE = 64'd65534;
  localparam int RESET_CYCLES = 10;
  localparam int HOLD_CYCLES = 80;
  localparam int SETTLE_CYCLES = 8;
  localparam int WATCHDOG_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] stream_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  result_kind;
  logic [8:0]  pixel_row;
  logic [8:0]  pixel_col;
  logic [16:0] region_index;
  logic [15:0] pixel_value;
  logic        over_threshold;
  logic [15:0] buffer_id;
  logic [47:0] time_tick;
  logic [31:0] run_seconds;
  logic [16:0] over_count;
  logic        last_of_event;

  roi_event_frame_parser_unit #(.COLS(COLS), .ROWS(ROWS)) dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .stream_word(stream_word),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_kind(result_kind), .pixel_row(pixel_row), .pixel_col(pixel_col),
    .region_index(region_index), .pixel_value(pixel_value),
    .over_threshold(over_threshold), .buffer_id(buffer_id), .time_tick(time_tick),
    .run_seconds(run_seconds), .over_count(over_count), .last_of_event(last_of_event)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic [15:0]         word_q[$];
  roiefp_pkg::result_t parsed_results_q[$];
  roiefp_pkg::result_t seen_result;
  roiefp_pkg::result_t want_result;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic        hold_req = 1'b0;
  int          hold_left = 0;
  int          idle_cycles = 0;
  int          errors = 0;
  int          words_taken = 0;
  int          kind_seen[4];

  // Parser state as seen by the predictor
  roiefp_pkg::phase_t parse_state = roiefp_pkg::PH_HUNT;
  logic [15:0] threshold = '0;
  logic [15:0] hdr_col_lo = '0, hdr_col_hi = '0, hdr_row_lo = '0, hdr_row_hi = '0;
  logic [15:0] sweep_row = '0, sweep_col = '0;
  logic        region_oob = 1'b0;
  logic [15:0] ev_buffer = '0, ev_time_lo = '0, ev_time_hi = '0;
  logic [15:0] last_time_hi = '0;
  logic        seen_time_hi = 1'b0;
  logic [15:0] wrap_count = '0;
  logic [31:0] ev_run = '0;
  logic [16:0] ev_over = '0;

  function automatic void add_word(input logic [15:0] w);
    word_q.insert(word_q.size(), w);
  endfunction

  function automatic void add_result(input roiefp_pkg::result_t r);
    parsed_results_q.insert(parsed_results_q.size(), r);
  endfunction

  function automatic void decode_word(input logic [15:0] w);
    roiefp_pkg::result_t r;
    logic [63:0] idx;
    logic [63:0] tick;
    logic        at_end;
    at_end = 1'b0;
    r = '0;
    case (parse_state)
      roiefp_pkg::PH_COLMIN: begin
        hdr_col_lo = w;
        parse_state = roiefp_pkg::PH_COLMAX;
      end
      roiefp_pkg::PH_COLMAX: begin
        hdr_col_hi = w;
        parse_state = roiefp_pkg::PH_ROWMIN;
      end
      roiefp_pkg::PH_ROWMIN: begin
        hdr_row_lo = w;
        parse_state = roiefp_pkg::PH_ROWMAX;
      end
      roiefp_pkg::PH_ROWMAX: begin
        hdr_row_hi = w;
        if (hdr_col_lo > hdr_col_hi || hdr_row_lo > hdr_row_hi) begin
          r.kind = roiefp_pkg::KIND_EMPTY;
          r.last = 1'b1;
          add_result(r);
          parse_state = roiefp_pkg::PH_HUNT;
        end else begin
          region_oob = (hdr_col_hi > COLS - 1) || (hdr_row_hi > ROWS - 1);
          parse_state = roiefp_pkg::PH_BUFID;
        end
      end
      roiefp_pkg::PH_BUFID: begin
        ev_buffer = w;
        parse_state = roiefp_pkg::PH_TLOW;
      end
      roiefp_pkg::PH_TLOW: begin
        ev_time_lo = w;
        parse_state = roiefp_pkg::PH_THIGH;
      end
      roiefp_pkg::PH_THIGH: begin
        ev_time_hi = w;
        // count a microsecond clock wrap between consecutive events
        if (seen_time_hi && last_time_hi > roiefp_pkg::ROLL_HIGH_MIN &&
            w < roiefp_pkg::ROLL_LOW_MAX)
          wrap_count = wrap_count + 16'd1;
        last_time_hi = w;
        seen_time_hi = 1'b1;
        parse_state = roiefp_pkg::PH_RUN1;
      end
      roiefp_pkg::PH_RUN1: begin
        ev_run = {w, 16'h0000};
        parse_state = roiefp_pkg::PH_RUN2;
      end
      roiefp_pkg::PH_RUN2: begin
        ev_run[15:0] = w;
        sweep_row = hdr_row_lo;
        sweep_col = hdr_col_lo;
        ev_over = '0;
        parse_state = roiefp_pkg::PH_PIX;
      end
      roiefp_pkg::PH_PIX: begin
        if (!region_oob) begin
          idx = 64'(sweep_row - hdr_row_lo)
              + 64'(sweep_col - hdr_col_lo) * (64'(hdr_col_hi - hdr_col_lo) + 64'd1);
          r.kind = roiefp_pkg::KIND_PIXEL;
          r.row = sweep_row[8:0];
          r.col = sweep_col[8:0];
          r.index = idx[16:0];
          r.value = w;
          r.over = (w > threshold);
          r.buffer_id = ev_buffer;
          add_result(r);
          if (r.over && ev_over != roiefp_pkg::OVER_SAT)
            ev_over = ev_over + 17'd1;
        end
        // advance column first, then row
        if (sweep_col == hdr_col_hi) begin
          sweep_col = hdr_col_lo;
          if (sweep_row == hdr_row_hi)
            at_end = 1'b1;
          else
            sweep_row = sweep_row + 16'd1;
        end else begin
          sweep_col = sweep_col + 16'd1;
        end
        if (at_end) begin
          tick = 64'(ev_time_lo) + 64'(ev_time_hi) * TICK_HIGH_SCALE
               + (64'(wrap_count) << 32);
          r = '0;
          r.kind = region_oob ? roiefp_pkg::KIND_BOUNDS : roiefp_pkg::KIND_SUMMARY;
          r.buffer_id = ev_buffer;
          r.tick = tick[47:0];
          r.run_seconds = ev_run;
          r.over_count = region_oob ? 17'd0 : ev_over;
          r.last = 1'b1;
          add_result(r);
          parse_state = roiefp_pkg::PH_HUNT;
        end
      end
      default: parse_state = (w == roiefp_pkg::SYNC_WORD) ? roiefp_pkg::PH_COLMIN
                                                          : roiefp_pkg::PH_HUNT;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [63:0] exp,
                                      input logic [63:0] act);
    if (exp !== act) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp, act);
      errors++;
    end
  endfunction

  // Pixel words cluster around the threshold and the range ends
  function automatic logic [15:0] pixel_word();
    case ($urandom_range(7))
      0: return threshold;
      1: return threshold + 16'd1;
      2: return threshold - 16'd1;
      3: return 16'h0000;
      4: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] place_in_bounds(input int span, input int limit);
    case ($urandom_range(3))
      0: return 16'd0;
      1: return 16'(limit - span);
      default: return 16'($urandom_range(limit - span));
    endcase
  endfunction

  function automatic logic [15:0] place_out_of_bounds(input int span, input int limit);
    if ($urandom_range(1))
      return 16'($urandom_range(limit - span + 1, limit));
    return 16'($urandom_range(limit, 65536 - span));
  endfunction

  task automatic push_frame(input logic [15:0] cmin, cmax, rmin, rmax, buf_word, tlo, thi,
                            run_hi, run_lo, input int fixed_pixel);
    longint npix;
    add_word(roiefp_pkg::SYNC_WORD);
    add_word(cmin);
    add_word(cmax);
    add_word(rmin);
    add_word(rmax);
    if (cmin <= cmax && rmin <= rmax) begin
      add_word(buf_word);
      add_word(tlo);
      add_word(thi);
      add_word(run_hi);
      add_word(run_lo);
      npix = (longint'(cmax) - cmin + 1) * (longint'(rmax) - rmin + 1);
      repeat (npix)
        add_word(fixed_pixel < 0 ? pixel_word() : 16'(fixed_pixel));
    end
  endtask

  task automatic add_random_frame();
    int          w;
    int          h;
    int          pick;
    logic [15:0] cmin, cmax, rmin, rmax, a, b, thi, noise;
    // line noise ahead of the sync word
    repeat ($urandom_range(2)) begin
      noise = 16'($urandom);
      if (noise == roiefp_pkg::SYNC_WORD)
        noise = 16'h0000;
      add_word(noise);
    end
    w = $urandom_range(1, 6);
    h = $urandom_range(1, 4);
    pick = $urandom_range(99);
    cmin = place_in_bounds(w, COLS);
    rmin = place_in_bounds(h, ROWS);
    if (pick >= 62 && pick < 80) begin
      if ($urandom_range(1))
        cmin = place_out_of_bounds(w, COLS);
      else
        rmin = place_out_of_bounds(h, ROWS);
    end
    cmax = cmin + 16'(w - 1);
    rmax = rmin + 16'(h - 1);
    if (pick >= 80) begin
      a = 16'($urandom);
      b = 16'($urandom);
      if (a == b)
        b = a + 16'd1;
      if ($urandom_range(1)) begin
        cmin = (a > b) ? a : b;
        cmax = (a > b) ? b : a;
        rmin = 16'($urandom);
        rmax = 16'($urandom);
      end else begin
        rmin = (a > b) ? a : b;
        rmax = (a > b) ? b : a;
        cmin = 16'($urandom);
        cmax = 16'($urandom);
      end
    end
    // bias the high time word toward the wrap window
    case ($urandom_range(2))
      0: thi = 16'($urandom);
      1: thi = 16'($urandom_range(65505, 65535));
      default: thi = 16'($urandom_range(0, 25));
    endcase
    push_frame(cmin, cmax, rmin, rmax, 16'($urandom), 16'($urandom), thi,
               16'($urandom), 16'($urandom), -1);
  endtask

  task automatic run_phase(input int thr, input int sidle, input int ridle,
                           input bit directed, input int budget, input bit pressure);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= 16'(thr);
    @(posedge clk);
    cfg_write <= 1'b0;
    threshold = 16'(thr);
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    if (pressure)
      hold_req <= 1'b1;
    if (directed) begin
      add_word(16'h0000);
      push_frame(16'd5, 16'd4, 16'd0, 16'd0, '0, '0, '0, '0, '0, -1);
      // corner pixel, all-ones data inside the frame
      push_frame(16'(COLS - 1), 16'(COLS - 1), 16'(ROWS - 1), 16'(ROWS - 1),
                 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      // row past the edge, time high wraps from all ones to zero
      push_frame(16'd0, 16'd0, 16'(ROWS), 16'(ROWS), '0, '0, '0, '0, '0, 0);
    end
    while (word_q.size() < budget)
      add_random_frame();
    do @(posedge clk);
    while (word_q.size() != 0 || in_valid || parsed_results_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Stream word driver
  always @(posedge clk) begin
    if (in_valid && in_ready) begin
      decode_word(stream_word);
      words_taken++;
    end
    if (!rst && (!in_valid || in_ready)) begin
      if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        stream_word <= word_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor and receiver back-pressure
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      seen_result.kind = result_kind;
      seen_result.row = pixel_row;
      seen_result.col = pixel_col;
      seen_result.index = region_index;
      seen_result.value = pixel_value;
      seen_result.over = over_threshold;
      seen_result.buffer_id = buffer_id;
      seen_result.tick = time_tick;
      seen_result.run_seconds = run_seconds;
      seen_result.over_count = over_count;
      seen_result.last = last_of_event;
      kind_seen[result_kind]++;
      if (parsed_results_q.size() == 0) begin
        $display("%0t: result with nothing expected, kind %0d", $time, result_kind);
        errors++;
      end else begin
        want_result = parsed_results_q.pop_front();
        check_field("result_kind", want_result.kind, seen_result.kind);
        check_field("pixel_row", want_result.row, seen_result.row);
        check_field("pixel_col", want_result.col, seen_result.col);
        check_field("region_index", want_result.index, seen_result.index);
        check_field("pixel_value", want_result.value, seen_result.value);
        check_field("over_threshold", want_result.over, seen_result.over);
        check_field("buffer_id", want_result.buffer_id, seen_result.buffer_id);
        check_field("time_tick", want_result.tick, seen_result.tick);
        check_field("run_seconds", want_result.run_seconds, seen_result.run_seconds);
        check_field("over_count", want_result.over_count, seen_result.over_count);
        check_field("last_of_event", want_result.last, seen_result.last);
      end
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_req <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Drop the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no request moved for %0d cycles", $time, idle_cycles);
      $display("roi_event_frame_parser_unit test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    run_phase(0, 8, 67, 1'b1, 233, 1'b0);
    run_phase(65535, 67, 8, 1'b0, 233, 1'b0);
    run_phase($urandom_range(1, 65534), 0, 0, 1'b0, 234, 1'b1);
    if (parsed_results_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, parsed_results_q.size());
      errors++;
    end
    $display("Decoded %0d stream words at three pixel thresholds", words_taken);
    $display("Checked %0d pixels, %0d summaries, %0d out-of-bounds, %0d empty regions",
             kind_seen[roiefp_pkg::KIND_PIXEL], kind_seen[roiefp_pkg::KIND_SUMMARY],
             kind_seen[roiefp_pkg::KIND_BOUNDS], kind_seen[roiefp_pkg::KIND_EMPTY]);
    if (errors == 0)
      $display("roi_event_frame_parser_unit test passed");
    else
      $display("roi_event_frame_parser_unit test failed");
    $finish;
  end

endmodule
